FILE: src/sle_pkg.sv
// Package for the sorted list engine: sizes, operation and status codes, and
// the control bundle that the top level broadcasts to every list cell.
// Depends on nothing.
package sle_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  // input kinds
  localparam logic [2:0] KIND_SORT_INS  = 3'd0;
  localparam logic [2:0] KIND_PUSH      = 3'd1;
  localparam logic [2:0] KIND_REM_FIRST = 3'd2;
  localparam logic [2:0] KIND_REM_ALL   = 3'd3;
  localparam logic [2:0] KIND_POP       = 3'd4;
  localparam logic [2:0] KIND_REM_POS   = 3'd5;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_BEYOND  = 2'd3;

  // cell operation modes
  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_INS_SORT  = 3'd1;
  localparam logic [2:0] MODE_INS_FRONT = 3'd2;
  localparam logic [2:0] MODE_REM_MATCH = 3'd3;
  localparam logic [2:0] MODE_REM_POS   = 3'd4;

  typedef struct packed {
    logic [2:0]              mode;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        pos;
    logic [CNT_W-1:0]        count;
  } cell_ctl_t;

endpackage

FILE: src/sorted_list_engine_core.sv
// Top level of the sorted list engine: command decode, count and result
// registers around a chain of sle_cell instances.
// Depends on sle_pkg and sle_cell.
//
//  channel  | handshake              | ports
//  ---------+------------------------+-------------------------------------------
//  input    | start & !busy          | in_kind, in_value, in_position
//  result   | out_valid, one cycle   | out_status, out_removed_count,
//           |                        | out_entry_count, out_head_value, out_list_empty
//
// Every kind except remove-all updates the cells at the accept edge and strobes
// the result in the next cycle, while the next transaction may already be
// accepted. Remove-all drops one matching entry per cycle until none is left,
// since the chain drops only the first match in each pass; busy stays high until
// the last pass finds no match. Synchronous reset empties the list; entries hold
// no reset value. The receiver cannot stall the result.
module sorted_list_engine_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_kind,
  input  logic signed [sle_pkg::VAL_W-1:0]  in_value,
  input  logic [sle_pkg::IDX_W-1:0]         in_position,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [4:0]                        out_removed_count,
  output logic [4:0]                        out_entry_count,
  output logic signed [sle_pkg::VAL_W-1:0]  out_head_value,
  output logic                              out_list_empty
);

  localparam int D = sle_pkg::DEPTH;

  logic                             busy_r;
  logic                             out_valid_r;
  logic [sle_pkg::CNT_W-1:0]        count_r;
  logic [1:0]                       status_r;
  logic [sle_pkg::CNT_W-1:0]        rem_r;
  logic signed [sle_pkg::VAL_W-1:0] val_r;

  logic                             accept;
  logic                             full;
  logic                             empty;
  logic                             beyond;
  logic                             found;
  sle_pkg::cell_ctl_t               ctl;

  logic signed [sle_pkg::VAL_W-1:0] entries [D];
  logic [D:0]                       found_chain;

  assign accept = start && !busy_r;
  assign full   = (count_r == sle_pkg::CNT_W'(D));
  assign empty  = (count_r == '0);
  assign beyond = (sle_pkg::CNT_W'(in_position) >= count_r);

  always_comb begin
    ctl.mode  = sle_pkg::MODE_NONE;
    ctl.value = in_value;
    ctl.pos   = in_position;
    ctl.count = count_r;
    if (busy_r) begin
      ctl.mode  = sle_pkg::MODE_REM_MATCH;
      ctl.value = val_r;
    end else if (accept) begin
      case (in_kind)
        sle_pkg::KIND_SORT_INS:
          if (!full) ctl.mode = sle_pkg::MODE_INS_SORT;
        sle_pkg::KIND_PUSH:
          if (!full) ctl.mode = sle_pkg::MODE_INS_FRONT;
        sle_pkg::KIND_REM_FIRST, sle_pkg::KIND_REM_ALL:
          ctl.mode = sle_pkg::MODE_REM_MATCH;
        sle_pkg::KIND_POP: begin
          ctl.pos = '0;
          if (!empty) ctl.mode = sle_pkg::MODE_REM_POS;
        end
        sle_pkg::KIND_REM_POS:
          if (!beyond) ctl.mode = sle_pkg::MODE_REM_POS;
        default: ctl.mode = sle_pkg::MODE_NONE;
      endcase
    end
  end

  assign found_chain[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < D; gi++) begin : g_cell
      logic signed [sle_pkg::VAL_W-1:0] left_w;
      logic signed [sle_pkg::VAL_W-1:0] right_w;
      if (gi == 0) begin : g_l0
        assign left_w = entries[gi];
      end else begin : g_ln
        assign left_w = entries[gi-1];
      end
      if (gi == D - 1) begin : g_rl
        assign right_w = entries[gi];
      end else begin : g_rn
        assign right_w = entries[gi+1];
      end
      sle_cell u_cell (
        .clk         (clk),
        .idx         (sle_pkg::IDX_W'(gi)),
        .ctl         (ctl),
        .left_entry  (left_w),
        .right_entry (right_w),
        .found_in    (found_chain[gi]),
        .found_out   (found_chain[gi+1]),
        .entry       (entries[gi])
      );
    end
  endgenerate

  assign found = found_chain[D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (busy_r) begin
        // keep dropping matches until a pass finds none
        if (found) begin
          rem_r   <= rem_r + 1'b1;
          count_r <= count_r - 1'b1;
        end else begin
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
          status_r    <= sle_pkg::ST_OK;
        end
      end else if (accept) begin
        val_r    <= in_value;
        rem_r    <= '0;
        status_r <= sle_pkg::ST_OK;
        case (in_kind)
          sle_pkg::KIND_SORT_INS, sle_pkg::KIND_PUSH: begin
            out_valid_r <= 1'b1;
            if (full) status_r <= sle_pkg::ST_FULL;
            else count_r <= count_r + 1'b1;
          end
          sle_pkg::KIND_REM_FIRST: begin
            out_valid_r <= 1'b1;
            if (found) begin
              rem_r   <= sle_pkg::CNT_W'(1);
              count_r <= count_r - 1'b1;
            end else begin
              status_r <= sle_pkg::ST_NOMATCH;
            end
          end
          sle_pkg::KIND_REM_ALL: begin
            if (found) begin
              busy_r  <= 1'b1;
              rem_r   <= sle_pkg::CNT_W'(1);
              count_r <= count_r - 1'b1;
            end else begin
              out_valid_r <= 1'b1;
              status_r    <= sle_pkg::ST_NOMATCH;
            end
          end
          sle_pkg::KIND_POP: begin
            out_valid_r <= 1'b1;
            if (empty) begin
              status_r <= sle_pkg::ST_NOMATCH;
            end else begin
              rem_r   <= sle_pkg::CNT_W'(1);
              count_r <= count_r - 1'b1;
            end
          end
          sle_pkg::KIND_REM_POS: begin
            out_valid_r <= 1'b1;
            if (beyond) begin
              status_r <= sle_pkg::ST_BEYOND;
            end else begin
              rem_r   <= sle_pkg::CNT_W'(1);
              count_r <= count_r - 1'b1;
            end
          end
          default: out_valid_r <= 1'b1;
        endcase
      end
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_count = 5'(rem_r);
  assign out_entry_count   = 5'(count_r);
  assign out_list_empty    = empty;
  assign out_head_value    = empty ? -32'sd1 : entries[0];

endmodule

FILE: src/sle_cell.sv
// One position of the sorted list chain: holds one entry, compares it against
// the broadcast operation, and shifts from a neighbor on insert or removal.
// Depends on sle_pkg.
module sle_cell (
  input  logic                              clk,
  input  logic [sle_pkg::IDX_W-1:0]         idx,
  input  sle_pkg::cell_ctl_t                ctl,
  input  logic signed [sle_pkg::VAL_W-1:0]  left_entry,
  input  logic signed [sle_pkg::VAL_W-1:0]  right_entry,
  input  logic                              found_in,
  output logic                              found_out,
  output logic signed [sle_pkg::VAL_W-1:0]  entry
);

  logic signed [sle_pkg::VAL_W-1:0] entry_r;
  logic signed [sle_pkg::VAL_W-1:0] entry_nxt;
  logic                             valid;
  logic                             hit;
  logic                             first;

  assign valid = sle_pkg::CNT_W'(idx) < ctl.count;

  always_comb begin
    case (ctl.mode)
      sle_pkg::MODE_INS_SORT:  hit = !(valid && (entry_r <= ctl.value));
      sle_pkg::MODE_INS_FRONT: hit = 1'b1;
      sle_pkg::MODE_REM_MATCH: hit = valid && (entry_r == ctl.value);
      sle_pkg::MODE_REM_POS:   hit = (idx == ctl.pos);
      default:                 hit = 1'b0;
    endcase
  end

  assign first     = hit && !found_in;
  assign found_out = found_in || hit;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.mode)
      sle_pkg::MODE_INS_SORT, sle_pkg::MODE_INS_FRONT: begin
        // move back behind the insertion point, take the new value at it
        if (found_in) entry_nxt = left_entry;
        else if (first) entry_nxt = ctl.value;
      end
      sle_pkg::MODE_REM_MATCH, sle_pkg::MODE_REM_POS: begin
        // close the gap from the right
        if (found_out) entry_nxt = right_entry;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

FILE: tb/sorted_list_engine_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_list_engine_core: a scoreboard class predicts
// every list operation and checks each strobed result. Depends on sle_pkg and the RTL.
module sorted_list_engine_core_test;

  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_LIMIT = 2000;
  localparam int TAIL_CYCLES = 2 * sle_pkg::DEPTH;
  localparam int PHASE_ITEMS = 488;
  localparam logic signed [sle_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [sle_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [1:0]                       status;
    logic [4:0]                       removed;
    logic [4:0]                       count;
    logic signed [sle_pkg::VAL_W-1:0] head;
    logic                             empty;
  } list_result_t;

  class list_scoreboard;
    logic signed [sle_pkg::VAL_W-1:0] slots [sle_pkg::DEPTH];
    int held;
    list_result_t pending [$];
    int errors;
    int commands;
    int checked;
    int drops;
    int bulk;
    int peak;

    function new();
      held = 0;
      errors = 0;
      commands = 0;
      checked = 0;
      drops = 0;
      bulk = 0;
      peak = 0;
    endfunction

    function void drop_at(int p);
      for (int i = p; i + 1 < held; i++) slots[i] = slots[i + 1];
      held--;
    endfunction

    function void insert_at(int p, logic signed [sle_pkg::VAL_W-1:0] v);
      for (int i = held; i > p; i--) slots[i] = slots[i - 1];
      slots[p] = v;
      held++;
    endfunction

    // Advance the predicted list by one accepted transaction and queue its result.
    function void note_command(logic [2:0] kind, logic signed [sle_pkg::VAL_W-1:0] value,
                               logic [sle_pkg::IDX_W-1:0] pos);
      list_result_t r;
      int i;
      int w;
      bit found;
      r.status = sle_pkg::ST_OK;
      r.removed = 5'd0;
      case (kind)
        sle_pkg::KIND_SORT_INS, sle_pkg::KIND_PUSH: begin
          if (held >= sle_pkg::DEPTH) begin
            r.status = sle_pkg::ST_FULL;
            drops++;
          end else if (kind == sle_pkg::KIND_PUSH) begin
            insert_at(0, value);
          end else begin
            i = 0;
            while (i < held && slots[i] <= value) i++;
            insert_at(i, value);
          end
        end
        sle_pkg::KIND_REM_FIRST: begin
          found = 1'b0;
          for (i = 0; i < held && !found; i++) begin
            if (slots[i] == value) begin
              drop_at(i);
              found = 1'b1;
            end
          end
          r.status = found ? sle_pkg::ST_OK : sle_pkg::ST_NOMATCH;
          r.removed = found ? 5'd1 : 5'd0;
        end
        sle_pkg::KIND_REM_ALL: begin
          w = 0;
          for (i = 0; i < held; i++) begin
            if (slots[i] == value) begin
              r.removed = r.removed + 5'd1;
            end else begin
              slots[w] = slots[i];
              w++;
            end
          end
          held = w;
          r.status = (r.removed != 5'd0) ? sle_pkg::ST_OK : sle_pkg::ST_NOMATCH;
          if (r.removed > 5'd1) bulk++;
        end
        sle_pkg::KIND_POP: begin
          if (held == 0) begin
            r.status = sle_pkg::ST_NOMATCH;
          end else begin
            drop_at(0);
            r.removed = 5'd1;
          end
        end
        sle_pkg::KIND_REM_POS: begin
          if (int'(pos) >= held) begin
            r.status = sle_pkg::ST_BEYOND;
          end else begin
            drop_at(int'(pos));
            r.removed = 5'd1;
          end
        end
        default: begin
        end
      endcase
      r.count = 5'(held);
      r.head = (held == 0) ? -32'sd1 : slots[0];
      r.empty = (held == 0);
      if (held > peak) peak = held;
      commands++;
      pending.push_back(r);
    endfunction

    function void report(string field, longint e, longint a);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, e, a);
      errors++;
    endfunction

    function void check_result(logic [1:0] status, logic [4:0] removed, logic [4:0] count,
                               logic signed [sle_pkg::VAL_W-1:0] head, logic empty);
      list_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result strobed with no transaction waiting", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (status !== e.status) report("status", e.status, status);
      if (removed !== e.removed) report("removed_count", e.removed, removed);
      if (count !== e.count) report("entry_count", e.count, count);
      if (head !== e.head) report("head_value", e.head, head);
      if (empty !== e.empty) report("list_empty", e.empty, empty);
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [2:0]                       in_kind;
  logic signed [sle_pkg::VAL_W-1:0] in_value;
  logic [sle_pkg::IDX_W-1:0]        in_position;
  logic                             out_valid;
  logic [1:0]                       out_status;
  logic [4:0]                       out_removed_count;
  logic [4:0]                       out_entry_count;
  logic signed [sle_pkg::VAL_W-1:0] out_head_value;
  logic                             out_list_empty;

  list_scoreboard sb;
  int quiet_cycles;

  sorted_list_engine_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_count (out_removed_count),
    .out_entry_count   (out_entry_count),
    .out_head_value    (out_head_value),
    .out_list_empty    (out_list_empty)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Monitor and watchdog: sample at the edge, before any driven update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(out_status, out_removed_count, out_entry_count, out_head_value,
                        out_list_empty);
      if (start && !busy) sb.note_command(in_kind, in_value, in_position);
      if (out_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Hold the command until the block takes it.
  task automatic issue(input logic [2:0] kind, input logic signed [sle_pkg::VAL_W-1:0] value,
                       input logic [sle_pkg::IDX_W-1:0] pos);
    start <= 1'b1;
    in_kind <= kind;
    in_value <= value;
    in_position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      in_value <= $urandom();
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // Mostly a narrow pool so matches and duplicates are common.
  function automatic logic signed [sle_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $signed($urandom_range(5)) - 32'sd3;
    if (r < 65) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_kind(bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 35) return sle_pkg::KIND_SORT_INS;
      if (r < 60) return sle_pkg::KIND_PUSH;
      if (r < 70) return sle_pkg::KIND_REM_FIRST;
      if (r < 78) return sle_pkg::KIND_REM_ALL;
      if (r < 86) return sle_pkg::KIND_POP;
      if (r < 96) return sle_pkg::KIND_REM_POS;
    end else begin
      if (r < 15) return sle_pkg::KIND_SORT_INS;
      if (r < 25) return sle_pkg::KIND_PUSH;
      if (r < 45) return sle_pkg::KIND_REM_FIRST;
      if (r < 60) return sle_pkg::KIND_REM_ALL;
      if (r < 75) return sle_pkg::KIND_POP;
      if (r < 95) return sle_pkg::KIND_REM_POS;
    end
    return $urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7;
  endfunction

  initial begin
    int idle_pct [4];
    int run_left;
    int guard;
    bit filling;
    idle_pct = '{0, 50, 0, 33};
    sb = new();
    quiet_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = sle_pkg::KIND_SORT_INS;
    in_value = '0;
    in_position = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-list cases, spare kinds, value extremes, misses and bulk removal
    issue(sle_pkg::KIND_POP, 32'sd0, 4'd0);
    issue(sle_pkg::KIND_REM_FIRST, 32'sd5, 4'd0);
    issue(sle_pkg::KIND_REM_ALL, 32'sd5, 4'd0);
    issue(sle_pkg::KIND_REM_POS, 32'sd0, 4'd0);
    issue(KIND_SPARE_6, 32'sd7, 4'd15);
    issue(KIND_SPARE_7, -32'sd7, 4'd3);
    issue(sle_pkg::KIND_SORT_INS, VAL_MAX, 4'd0);
    issue(sle_pkg::KIND_SORT_INS, VAL_MIN, 4'd0);
    issue(sle_pkg::KIND_SORT_INS, -32'sd1, 4'd0);
    issue(sle_pkg::KIND_SORT_INS, 32'sd0, 4'd0);
    issue(sle_pkg::KIND_SORT_INS, 32'sd0, 4'd0);
    issue(sle_pkg::KIND_PUSH, 32'sh1234_5678, 4'd0);
    issue(sle_pkg::KIND_SORT_INS, 32'sh5555_5555, 4'd0);
    issue(sle_pkg::KIND_SORT_INS, 32'shaaaa_aaaa, 4'd0);
    issue(sle_pkg::KIND_REM_POS, 32'sd0, 4'd15);
    issue(sle_pkg::KIND_REM_POS, 32'sd0, 4'd2);
    issue(sle_pkg::KIND_REM_FIRST, 32'sd0, 4'd0);
    issue(sle_pkg::KIND_REM_FIRST, 32'sd3, 4'd0);
    issue(sle_pkg::KIND_PUSH, 32'sd0, 4'd0);
    issue(sle_pkg::KIND_PUSH, 32'sd0, 4'd0);
    issue(sle_pkg::KIND_REM_ALL, 32'sd0, 4'd0);
    issue(sle_pkg::KIND_REM_ALL, 32'sd99, 4'd0);
    issue(sle_pkg::KIND_POP, 32'sd0, 4'd0);
    issue(sle_pkg::KIND_REM_POS, 32'sd0, 4'd0);

    // random: alternate fill-heavy and drain-heavy runs so the list hits full and empty
    filling = 1'b1;
    run_left = 0;
    foreach (idle_pct[ph]) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          filling = ~filling;
          run_left = $urandom_range(60, 20);
        end
        run_left--;
        issue(pick_kind(filling), pick_value(), sle_pkg::IDX_W'($urandom_range(15)));
        idle_gap(idle_pct[ph]);
      end
    end
    start <= 1'b0;

    guard = 0;
    while (sb.pending.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end

    $display("Ran %0d list commands, checked %0d results, %0d inserts dropped on a full list,",
             sb.commands, sb.checked, sb.drops);
    $display("%0d remove-all transactions took several entries, deepest list %0d entries.",
             sb.bulk, sb.peak);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
